[design/pfm_pkg.sv]
// Package for packet_flow_monitor: shared types, protocol constants and widths.
// No dependencies.
package pfm_pkg;

  localparam logic [15:0] KIND_IPV4   = 16'h0800;
  localparam logic [7:0]  PROTO_TCP   = 8'd6;
  localparam logic [7:0]  PROTO_UDP   = 8'd17;
  localparam logic [4:0]  ETH_BYTES   = 5'd14;
  localparam logic [3:0]  UDP_BYTES   = 4'd8;
  localparam logic [1:0]  CLEAR_AFTER = 2'd3;

  localparam logic [1:0] CLS_NONIP = 2'd0;
  localparam logic [1:0] CLS_OTHER = 2'd1;
  localparam logic [1:0] CLS_TCP   = 2'd2;
  localparam logic [1:0] CLS_UDP   = 2'd3;

  localparam int IN_BITS  = 176;
  localparam int IN_BYTES = 22;

  // Classified frame handed from front to back.
  typedef struct packed {
    logic [1:0]  cls;
    logic [63:0] akey;
    logic [39:0] pkey;
    logic [31:0] seq;
    logic [16:0] payload;
    logic [15:0] caplen;
  } job_t;

  typedef struct packed {
    logic [1:0]  cls;
    logic        retx;
    logic        fresh;
    logic        full;
    logic [16:0] payload;
    logic [31:0] tcp_flow;
    logic [31:0] udp_flow;
    logic [31:0] frames;
    logic [31:0] tcp_frames;
    logic [31:0] udp_frames;
    logic [31:0] tcp_bytes;
    logic [31:0] udp_bytes;
  } res_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

[design/pfm_front.sv]
// Front end: accepts header transactions, classifies them, computes payload length.
// Depends on pfm_pkg.
module pfm_front import pfm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_BITS-1:0]   in_fields,
  output logic                 job_valid,
  input  logic                 job_ready,
  output job_t                 job
);
  logic [15:0] kind, sport, dport, caplen;
  logic [3:0]  ihl, toff;
  logic [7:0]  proto;
  logic [31:0] src, dst, seq;
  logic        valid_r;
  job_t        job_r, job_nxt;
  logic [16:0] hdr;

  assign {caplen, toff, seq, dport, sport, dst, src, proto, ihl, kind} = in_fields;
  assign in_tready = !valid_r || job_ready;
  assign job_valid = valid_r;
  assign job = job_r;

  always_comb begin
    job_nxt = '0;
    hdr = {12'd0, ETH_BYTES} + {11'd0, ihl, 2'b00};
    job_nxt.akey = {src, dst};
    job_nxt.pkey = {sport, dport, proto};
    job_nxt.seq = seq;
    job_nxt.caplen = caplen;
    if (kind != KIND_IPV4) begin
      job_nxt.cls = CLS_NONIP;
    end else if (proto == PROTO_TCP) begin
      job_nxt.cls = CLS_TCP;
      hdr = hdr + {11'd0, toff, 2'b00};
    end else if (proto == PROTO_UDP) begin
      job_nxt.cls = CLS_UDP;
      hdr = hdr + {13'd0, UDP_BYTES};
    end else begin
      job_nxt.cls = CLS_OTHER;
    end
    if (job_nxt.cls == CLS_TCP || job_nxt.cls == CLS_UDP) begin
      job_nxt.payload = {1'b0, caplen} - hdr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      job_r <= job_nxt;
    end
  end
endmodule

[design/pfm_queue.sv]
// Two-entry queue between front and back ends.
// Depends on pfm_pkg.
module pfm_queue import pfm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_data
);
  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
    if (wr) mem_r[wp_r] <= wr_data;
  end
endmodule

[design/pfm_back.sv]
// Back end: counters, sequence history and flow table scan; one frame at a time.
// Depends on pfm_pkg.
module pfm_back import pfm_pkg::*; #(
  parameter int FLOW_ENTRIES = 64,
  parameter int SEQ_HISTORY  = 3
) (
  input  logic clk,
  input  logic rst_n,
  input  logic job_valid,
  output logic job_ready,
  input  job_t job,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);
  localparam int FW = $clog2(FLOW_ENTRIES);
  localparam int HW = $clog2(SEQ_HISTORY + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [63:0] addr_mem [FLOW_ENTRIES];
  logic [39:0] port_mem [FLOW_ENTRIES];
  logic [63:0] rd_addr_r;
  logic [39:0] rd_port_r;
  logic [31:0] hist_r [SEQ_HISTORY];

  logic [1:0]  state_r;
  logic [FW:0] fill_r, idx_r;
  logic [HW-1:0] hfill_r;
  logic [1:0]  since_r;
  logic [31:0] c_frame_r, c_tf_r, c_uf_r, c_tb_r, c_ub_r, c_tfl_r, c_ufl_r;
  job_t        job_r;
  logic        out_valid_r;
  res_t        res_r;
  logic        retx_r;

  // history check is small and done at once
  logic [HW-1:0] hf_eff;
  logic          hit;
  always_comb begin
    hf_eff = (since_r == CLEAR_AFTER) ? '0 : hfill_r;
    hit = 1'b0;
    for (int i = 0; i < SEQ_HISTORY; i++) begin
      if (HW'(i) < hf_eff && hist_r[i] == job.seq) hit = 1'b1;
    end
  end

  assign job_ready = state_r == ST_IDLE && !out_valid_r;
  assign res_valid = out_valid_r;
  assign res = res_r;

  logic is_fl;
  assign is_fl = job.cls == CLS_TCP || job.cls == CLS_UDP;
  logic match;
  assign match = rd_addr_r == job_r.akey && rd_port_r == job_r.pkey;

  always_ff @(posedge clk) begin
    rd_addr_r <= addr_mem[idx_r[FW-1:0]];
    rd_port_r <= port_mem[idx_r[FW-1:0]];
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r <= '0;
      hfill_r <= '0;
      since_r <= '0;
      out_valid_r <= 1'b0;
      idx_r <= '0;
      {c_frame_r, c_tf_r, c_uf_r, c_tb_r, c_ub_r, c_tfl_r, c_ufl_r} <= '0;
    end else begin
      if (res_valid && res_ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (job_valid && job_ready) begin
            job_r <= job;
            retx_r <= 1'b0;
            idx_r <= '0;
            c_frame_r <= sat_add(c_frame_r, 32'd1);
            if (job.cls == CLS_TCP) begin
              c_tf_r <= sat_add(c_tf_r, 32'd1);
              c_tb_r <= sat_add(c_tb_r, {16'd0, job.caplen});
              since_r <= (since_r == CLEAR_AFTER) ? 2'd0 : since_r + 2'd1;
              retx_r <= hit;
              if (!hit && hf_eff < HW'(SEQ_HISTORY)) begin
                hist_r[hf_eff[HW-1:0] < HW'(SEQ_HISTORY) ? hf_eff : '0] <= job.seq;
                hfill_r <= hf_eff + HW'(1);
              end else begin
                hfill_r <= hf_eff;
              end
            end else if (job.cls == CLS_UDP) begin
              c_uf_r <= sat_add(c_uf_r, 32'd1);
              c_ub_r <= sat_add(c_ub_r, {16'd0, job.caplen});
            end
            state_r <= is_fl ? ST_SCAN : ST_DONE;
          end
        end
        ST_SCAN: begin
          // read issued for idx_r; data arrives next cycle
          if (idx_r >= fill_r) begin
            state_r <= ST_DONE;
          end else begin
            state_r <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (match) begin
            job_r.cls <= job_r.cls;
            idx_r <= fill_r + 1'b1;
            state_r <= ST_DONE;
            fill_r <= fill_r;
          end else begin
            idx_r <= idx_r + 1'b1;
            state_r <= ST_SCAN;
          end
        end
        ST_DONE: begin
          res_r.cls <= job_r.cls;
          res_r.retx <= retx_r;
          res_r.payload <= job_r.payload;
          res_r.fresh <= 1'b0;
          res_r.full <= 1'b0;
          res_r.frames <= c_frame_r;
          res_r.tcp_frames <= c_tf_r;
          res_r.udp_frames <= c_uf_r;
          res_r.tcp_bytes <= c_tb_r;
          res_r.udp_bytes <= c_ub_r;
          res_r.tcp_flow <= c_tfl_r;
          res_r.udp_flow <= c_ufl_r;
          if ((job_r.cls == CLS_TCP || job_r.cls == CLS_UDP) && idx_r == fill_r) begin
            if (fill_r < (FW+1)'(FLOW_ENTRIES)) begin
              addr_mem[fill_r[FW-1:0]] <= job_r.akey;
              port_mem[fill_r[FW-1:0]] <= job_r.pkey;
              fill_r <= fill_r + 1'b1;
              res_r.fresh <= 1'b1;
              if (job_r.cls == CLS_TCP) begin
                c_tfl_r <= sat_add(c_tfl_r, 32'd1);
                res_r.tcp_flow <= sat_add(c_tfl_r, 32'd1);
              end else begin
                c_ufl_r <= sat_add(c_ufl_r, 32'd1);
                res_r.udp_flow <= sat_add(c_ufl_r, 32'd1);
              end
            end else begin
              res_r.full <= 1'b1;
            end
          end
          out_valid_r <= 1'b1;
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule

[design/packet_flow_monitor.sv]
// Top level of packet_flow_monitor: front end, queue and back end.
// Depends on pfm_pkg, pfm_front, pfm_queue, pfm_back.
//
// One header transaction in, one result transaction out, in order. The front
// classifies the frame and computes payload length combinationally into its
// output register; the back end scans the flow table one entry at a time through
// a registered memory read and holds a TCP/UDP frame until the scan ends at a
// match or at the table fill. The front register and the queue lie between the
// input and the back end. Sequence history is checked in the accept cycle.
module packet_flow_monitor import pfm_pkg::*; #(
  parameter int FLOW_ENTRIES = 64,
  parameter int SEQ_HISTORY  = 3
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // ether_kind, ip_header_words, ip_protocol, source_address, destination_address,
  // source_port_number, destination_port_number, tcp_sequence, tcp_offset_words,
  // captured_length
  input  logic [175:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // retransmission, new_flow, table_full, payload_bytes, tcp_flow_total,
  // udp_flow_total, frame_total, tcp_frame_total, udp_frame_total,
  // tcp_byte_total, udp_byte_total
  output logic [247:0] out_tdata,
  // packet_class
  output logic [1:0]   out_tuser
);
  logic j_valid, j_ready, q_valid, q_ready, r_valid;
  job_t j_data, q_data;
  res_t r;

  pfm_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_fields(in_tdata),
    .job_valid(j_valid), .job_ready(j_ready), .job(j_data)
  );

  pfm_queue u_queue (
    .clk, .rst_n, .wr_valid(j_valid), .wr_ready(j_ready), .wr_data(j_data),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  pfm_back #(.FLOW_ENTRIES(FLOW_ENTRIES), .SEQ_HISTORY(SEQ_HISTORY)) u_back (
    .clk, .rst_n, .job_valid(q_valid), .job_ready(q_ready), .job(q_data),
    .res_valid(r_valid), .res_ready(out_tready), .res(r)
  );

  assign out_tvalid = r_valid;
  assign out_tuser = r.cls;
  assign out_tdata = {4'b0000, r.udp_bytes, r.tcp_bytes, r.udp_frames, r.tcp_frames,
                      r.frames, r.udp_flow, r.tcp_flow, r.payload, r.full,
                      r.fresh, r.retx};
endmodule

[design/pfm_checker.sv]
// Port-level checker for packet_flow_monitor, bound to the top level.
// Depends on pfm_pkg.
module pfm_checker import pfm_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [247:0] out_tdata,
  input logic [1:0]   out_tuser
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped while stalled");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[1] && out_tdata[2]))
    else $error("new_flow and table_full together");
  a_nonip: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == CLS_NONIP || out_tuser == CLS_OTHER) |->
    out_tdata[19:0] == 20'd0)
    else $error("non-flow frame carries flags");
  a_udp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == CLS_UDP |-> !out_tdata[0])
    else $error("retransmission on udp");
endmodule

bind packet_flow_monitor pfm_checker u_pfm_checker (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata, .out_tuser
);
